/* rtl/pomppt_pkg.sv */
// ----------------------------------------------------------------------------
// pomppt_pkg
// Shared types and constants of the perturb-and-observe MPPT core.
// ----------------------------------------------------------------------------
package pomppt_pkg;

    localparam int DutyW  = 8;
    localparam int IncW   = 7;
    localparam int VoltW  = 16;
    localparam int CurrW  = 16;
    localparam int PowerW = VoltW + CurrW;
    localparam int AddrW  = 5;
    localparam int DataW  = 32;

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_DISABLE = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SEARCH  = 3'd1,
        MODE_TRACK   = 3'd2,
        MODE_LIMITED = 3'd3,
        MODE_FAULT   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REG_DUTY_LOW  = 3'd0,
        REG_DUTY_HIGH = 3'd1,
        REG_DUTY_INIT = 3'd2,
        REG_DUTY_INC  = 3'd3,
        REG_MIN_VIN   = 3'd4,
        REG_DEADBAND  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [DutyW-1:0]  duty_low;
        logic [DutyW-1:0]  duty_high;
        logic [DutyW-1:0]  duty_init;
        logic [IncW-1:0]   duty_inc;
        logic [VoltW-1:0]  min_vin;
        logic [PowerW-1:0] deadband;
    } t_cfg;

    typedef struct packed {
        t_mode             mode;
        logic [DutyW-1:0]  duty;
        logic [PowerW-1:0] last_power;
        logic              dir_up;
        logic              enabled;
        logic              have_last;
        logic              drive;
    } t_state;

    localparam t_cfg CFG_RESET = '{
        duty_low:  8'd13,
        duty_high: 8'd252,
        duty_init: 8'd77,
        duty_inc:  7'd4,
        min_vin:   16'd5000,
        deadband:  32'd100000
    };

    localparam t_state STATE_RESET = '{
        mode:       MODE_IDLE,
        duty:       8'd77,
        last_power: '0,
        dir_up:     1'b1,
        enabled:    1'b0,
        have_last:  1'b0,
        drive:      1'b0
    };

endpackage

/* rtl/pomppt_regs.sv */
// ----------------------------------------------------------------------------
// pomppt_regs
// APB register file holding the tracker limits, step size and thresholds.
// ----------------------------------------------------------------------------
module pomppt_regs
    import pomppt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    t_reg_idx   w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[AddrW-1:2]);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_DUTY_LOW:  r_cfg.duty_low  <= pwdata[DutyW-1:0];
                REG_DUTY_HIGH: r_cfg.duty_high <= pwdata[DutyW-1:0];
                REG_DUTY_INIT: r_cfg.duty_init <= pwdata[DutyW-1:0];
                REG_DUTY_INC:  r_cfg.duty_inc  <= pwdata[IncW-1:0];
                REG_MIN_VIN:   r_cfg.min_vin   <= pwdata[VoltW-1:0];
                REG_DEADBAND:  r_cfg.deadband  <= pwdata[PowerW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DUTY_LOW:  prdata = DataW'(r_cfg.duty_low);
            REG_DUTY_HIGH: prdata = DataW'(r_cfg.duty_high);
            REG_DUTY_INIT: prdata = DataW'(r_cfg.duty_init);
            REG_DUTY_INC:  prdata = DataW'(r_cfg.duty_inc);
            REG_MIN_VIN:   prdata = DataW'(r_cfg.min_vin);
            REG_DEADBAND:  prdata = DataW'(r_cfg.deadband);
            default:       prdata = '0;
        endcase
    end

endmodule

/* rtl/pomppt_step.sv */
// ----------------------------------------------------------------------------
// pomppt_step
// Next-state logic: applies one command or sample to the tracker state.
// ----------------------------------------------------------------------------
module pomppt_step
    import pomppt_pkg::*;
(
    input  t_state            i_state,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    input  logic [VoltW-1:0]  i_vin,
    input  logic [PowerW-1:0] i_power,
    output t_state            o_state
);

    logic              w_first;
    logic              w_reverse;
    logic              w_dir;
    logic [PowerW-1:0] w_drop;
    logic signed [9:0] w_sum;
    logic signed [9:0] w_high;
    logic signed [9:0] w_low;
    logic [DutyW-1:0]  w_duty;
    logic              w_limited;

    assign w_first   = !i_state.have_last || (i_state.mode == MODE_FAULT);
    assign w_drop    = i_state.last_power - i_power;
    assign w_reverse = (i_state.last_power > i_power) && (w_drop > i_cfg.deadband);
    assign w_dir     = w_first ? i_state.dir_up : (i_state.dir_up ^ w_reverse);
    assign w_high    = 10'(signed'({2'b00, i_cfg.duty_high}));
    assign w_low     = 10'(signed'({2'b00, i_cfg.duty_low}));

    always_comb begin
        if (w_dir) begin
            w_sum = 10'(signed'({2'b00, i_state.duty})) + 10'(signed'({3'b000, i_cfg.duty_inc}));
        end else begin
            w_sum = 10'(signed'({2'b00, i_state.duty})) - 10'(signed'({3'b000, i_cfg.duty_inc}));
        end
        w_limited = 1'b1;
        if (w_sum > w_high) begin
            w_duty = i_cfg.duty_high;
        end else if (w_sum < w_low) begin
            w_duty = i_cfg.duty_low;
        end else begin
            w_duty    = w_sum[DutyW-1:0];
            w_limited = 1'b0;
        end
    end

    always_comb begin
        o_state = i_state;
        case (i_cmd)
            CMD_SAMPLE: begin
                if (!i_state.enabled) begin
                    o_state.mode = MODE_IDLE;
                end else if (i_vin < i_cfg.min_vin) begin
                    o_state.mode      = MODE_FAULT;
                    o_state.have_last = 1'b0;
                    o_state.drive     = 1'b0;
                end else begin
                    o_state.duty       = w_duty;
                    o_state.dir_up     = w_dir;
                    o_state.last_power = i_power;
                    o_state.have_last  = 1'b1;
                    o_state.drive      = 1'b1;
                    if (w_limited) begin
                        o_state.mode = MODE_LIMITED;
                    end else if (w_first) begin
                        o_state.mode = MODE_SEARCH;
                    end else begin
                        o_state.mode = MODE_TRACK;
                    end
                end
            end
            CMD_ENABLE: begin
                o_state.enabled    = 1'b1;
                o_state.mode       = MODE_SEARCH;
                o_state.duty       = i_cfg.duty_init;
                o_state.drive      = 1'b1;
                o_state.last_power = '0;
                o_state.dir_up     = 1'b1;
                o_state.have_last  = 1'b0;
            end
            CMD_DISABLE: begin
                o_state.enabled   = 1'b0;
                o_state.mode      = MODE_IDLE;
                o_state.have_last = 1'b0;
                o_state.drive     = 1'b0;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/perturb_observe_mppt_core.sv */
// ----------------------------------------------------------------------------
// perturb_observe_mppt_core
// Perturb-and-observe maximum power point tracker with an APB register port.
//
//   Channel  Dir  Handshake               Content
//   s_axis   in   s_axis_tvalid/tready    command, input voltage and current
//   m_axis   out  m_axis_tvalid/tready    duty code, mode, drive, direction
//   apb      in   psel/penable/pready     limits, step size, thresholds
//
// On acceptance the input power is multiplied into the input register; the
// state update and result are then formed into the output register. A word
// can be accepted every cycle while the output is not stalled.
// Reset is synchronous and restores the power-on registers and state.
// A stalled output holds its word while the input register still takes one.
// ----------------------------------------------------------------------------
module perturb_observe_mppt_core
    import pomppt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // vin_mv[15:0], iin_ma[31:16]
    input  logic [1:0]       s_axis_tuser,   // cmd[1:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // duty_code[7:0], mode[10:8],
                                             // drive_on[11], step_up[12], zero
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    t_cfg              w_cfg;
    t_state            r_state;
    t_state            n_state;
    logic              r_in_valid;
    t_cmd              r_in_cmd;
    logic [VoltW-1:0]  r_in_vin;
    logic [PowerW-1:0] r_in_power;
    logic              r_out_valid;
    logic [15:0]       r_out_data;
    logic              w_adv;
    logic              w_take;

    pomppt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pomppt_step u_step (
        .i_state (r_state),
        .i_cfg   (w_cfg),
        .i_cmd   (r_in_cmd),
        .i_vin   (r_in_vin),
        .i_power (r_in_power),
        .o_state (n_state)
    );

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_cmd   <= t_cmd'(s_axis_tuser);
            r_in_vin   <= s_axis_tdata[15:0];
            r_in_power <= PowerW'(s_axis_tdata[15:0]) * PowerW'(s_axis_tdata[31:16]);
        end
        if (w_adv) begin
            r_out_data <= {3'b000, n_state.dir_up, n_state.drive, n_state.mode, n_state.duty};
        end
    end

    a_fault_idle_drive_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_FAULT || r_state.mode == MODE_IDLE) |-> !r_state.drive)
        else $error("drive is on in fault or idle mode");

    a_active_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode != MODE_IDLE) |-> r_state.enabled)
        else $error("tracker is active while disabled");

    a_state_moves_with_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("state changed without a word");

    a_result_follows_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("processed word produced no result");

endmodule

/* dv/tb_perturb_observe_mppt_core.sv */
// ----------------------------------------------------------------------------
// tb_perturb_observe_mppt_core
// Self-checking testbench for the perturb-and-observe MPPT core.
//
// The bench drives commands and voltage and current samples into the input
// stream, and stalls both stream sides at random. It programs the register
// port only while the core is idle. A behavioral tracker in the bench
// predicts every output word. Each output word is compared field by field
// with the oldest expected entry (the table value for fixed directed words).
// The run starts with a short table of directed words, then covers several
// register settings with random, mostly well-formed sample sequences.
// ----------------------------------------------------------------------------
module tb_perturb_observe_mppt_core;
    import pomppt_pkg::*;

    typedef struct packed {
        logic [DutyW-1:0] duty;
        t_mode            mode;
        logic             drive;
        logic             up;
    } t_update;

    typedef struct {
        t_cmd             cmd;
        logic [VoltW-1:0] vin;
        logic [CurrW-1:0] iin;
        bit               fixed;
        t_update          upd;
    } t_row;

    localparam t_update NO_UPD    = '{8'd0, MODE_IDLE, 1'b0, 1'b0};
    localparam t_update IDLE_77   = '{8'd77, MODE_IDLE, 1'b0, 1'b1};
    localparam t_update SEARCH_77 = '{8'd77, MODE_SEARCH, 1'b1, 1'b1};
    localparam int      NUM_ROWS  = 22;
    localparam int      NUM_PHASES = 8;
    localparam int      PHASE_WORDS = 70;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata = '0;  // vin_mv[15:0], iin_ma[31:16]
    logic [1:0]       s_axis_tuser = '0;  // cmd[1:0]
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [15:0]      m_axis_tdata;       // duty_code[7:0], mode[10:8],
                                          // drive_on[11], step_up[12], zero
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [DataW-1:0] pwdata = '0;
    logic [DataW-1:0] prdata;
    logic             pready;

    t_cfg             trk_cfg;
    t_mode            trk_mode;
    logic [DutyW-1:0] trk_duty;
    logic [31:0]      trk_last_power;
    logic             trk_up;
    logic             trk_enabled;
    logic             trk_have_last;
    logic             trk_drive;

    t_update          expected_updates[$];
    int               n_err = 0;
    int               drift_ma = 2000;
    int               rdy_hold = 0;
    t_cfg             phase_cfg[NUM_PHASES];

    t_row directed_rows[NUM_ROWS] = '{
        '{CMD_SAMPLE,  16'd6000,  16'd1000,  1'b1, IDLE_77},
        '{CMD_UNUSED,  16'hFFFF,  16'hFFFF,  1'b1, IDLE_77},
        '{CMD_ENABLE,  16'd0,     16'd0,     1'b1, SEARCH_77},
        '{CMD_SAMPLE,  16'd4999,  16'hFFFF,  1'b1, '{8'd77, MODE_FAULT, 1'b0, 1'b1}},
        '{CMD_SAMPLE,  16'd5000,  16'd1000,  1'b1, '{8'd81, MODE_SEARCH, 1'b1, 1'b1}},
        '{CMD_SAMPLE,  16'd5000,  16'd1000,  1'b0, NO_UPD},
        '{CMD_SAMPLE,  16'd5000,  16'd979,   1'b0, NO_UPD},
        '{CMD_SAMPLE,  16'hFFFF,  16'hFFFF,  1'b0, NO_UPD},
        '{CMD_SAMPLE,  16'd0,     16'd0,     1'b0, NO_UPD},
        '{CMD_SAMPLE,  16'hFFFF,  16'd0,     1'b0, NO_UPD},
        '{CMD_DISABLE, 16'hFFFF,  16'hFFFF,  1'b0, NO_UPD},
        '{CMD_SAMPLE,  16'hFFFF,  16'hFFFF,  1'b0, NO_UPD},
        '{CMD_ENABLE,  16'd0,     16'd0,     1'b1, SEARCH_77},
        '{CMD_SAMPLE,  16'd5000,  16'd0,     1'b0, NO_UPD},
        '{CMD_ENABLE,  16'hFFFF,  16'hFFFF,  1'b1, SEARCH_77},
        '{CMD_UNUSED,  16'd0,     16'd0,     1'b0, NO_UPD},
        '{CMD_SAMPLE,  16'd5000,  16'd20,    1'b0, NO_UPD},
        '{CMD_SAMPLE,  16'd5000,  16'd0,     1'b0, NO_UPD},
        '{CMD_SAMPLE,  16'd5000,  16'd21,    1'b0, NO_UPD},
        '{CMD_SAMPLE,  16'd5000,  16'd0,     1'b0, NO_UPD},
        '{CMD_DISABLE, 16'd0,     16'd0,     1'b0, NO_UPD},
        '{CMD_SAMPLE,  16'd4999,  16'd0,     1'b0, NO_UPD}
    };

    perturb_observe_mppt_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic void perturb_duty();
        int d;
        d = int'(trk_duty);
        if (trk_up) begin
            d = d + int'(trk_cfg.duty_inc);
        end else begin
            d = d - int'(trk_cfg.duty_inc);
        end
        if (d > int'(trk_cfg.duty_high)) begin
            d = int'(trk_cfg.duty_high);
            trk_mode = MODE_LIMITED;
        end else if (d < int'(trk_cfg.duty_low)) begin
            d = int'(trk_cfg.duty_low);
            trk_mode = MODE_LIMITED;
        end else begin
            trk_mode = MODE_TRACK;
        end
        trk_duty = d[7:0];
        trk_drive = 1'b1;
    endfunction

    function automatic t_update track_power_point(t_cmd cmd, logic [VoltW-1:0] vin,
                                                  logic [CurrW-1:0] iin);
        logic [31:0] power;
        power = vin * iin;
        case (cmd)
            CMD_SAMPLE: begin
                if (!trk_enabled) begin
                    trk_mode = MODE_IDLE;
                end else if (vin < trk_cfg.min_vin) begin
                    trk_mode = MODE_FAULT;
                    trk_have_last = 1'b0;
                    trk_drive = 1'b0;
                end else begin
                    if (trk_mode == MODE_FAULT) begin
                        trk_mode = MODE_SEARCH;
                        trk_have_last = 1'b0;
                    end
                    if (!trk_have_last) begin
                        trk_last_power = power;
                        trk_have_last = 1'b1;
                        perturb_duty();
                        if (trk_mode != MODE_LIMITED) begin
                            trk_mode = MODE_SEARCH;
                        end
                    end else begin
                        if (trk_last_power > power &&
                            (trk_last_power - power) > trk_cfg.deadband) begin
                            trk_up = ~trk_up;
                        end
                        perturb_duty();
                        trk_last_power = power;
                    end
                end
            end
            CMD_ENABLE: begin
                trk_enabled = 1'b1;
                trk_mode = MODE_SEARCH;
                trk_duty = trk_cfg.duty_init;
                trk_drive = 1'b1;
                trk_last_power = '0;
                trk_up = 1'b1;
                trk_have_last = 1'b0;
            end
            CMD_DISABLE: begin
                trk_enabled = 1'b0;
                trk_mode = MODE_IDLE;
                trk_have_last = 1'b0;
                trk_drive = 1'b0;
            end
            default: begin
            end
        endcase
        return '{trk_duty, trk_mode, trk_drive, trk_up};
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.duty_low  = 8'($urandom_range(0, 120));
        c.duty_high = 8'($urandom_range(130, 255));
        c.duty_init = 8'($urandom_range(0, 255));
        c.duty_inc  = 7'($urandom_range(1, 64));
        c.min_vin   = 16'($urandom_range(0, 20000));
        c.deadband  = 32'($urandom_range(0, 3000000));
        return c;
    endfunction

    task automatic send_word(t_cmd cmd, logic [VoltW-1:0] vin, logic [CurrW-1:0] iin,
                             bit fixed, t_update want);
        t_update pred;
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = {iin, vin};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = track_power_point(cmd, vin, iin);
        expected_updates.push_back(fixed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic sender_gap(bit quiet);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            gap = 0;
        end else if (r < 93) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain_updates();
        s_axis_tvalid = 1'b0;
        while (expected_updates.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [DataW-1:0] val);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_DUTY_LOW:  trk_cfg.duty_low = val[DutyW-1:0];
            REG_DUTY_HIGH: trk_cfg.duty_high = val[DutyW-1:0];
            REG_DUTY_INIT: trk_cfg.duty_init = val[DutyW-1:0];
            REG_DUTY_INC:  trk_cfg.duty_inc = val[IncW-1:0];
            REG_MIN_VIN:   trk_cfg.min_vin = val[VoltW-1:0];
            REG_DEADBAND:  trk_cfg.deadband = val[PowerW-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic apply_cfg(t_cfg c);
        cfg_write(REG_DUTY_LOW, 32'(c.duty_low));
        cfg_write(REG_DUTY_HIGH, 32'(c.duty_high));
        cfg_write(REG_DUTY_INIT, 32'(c.duty_init));
        cfg_write(REG_DUTY_INC, 32'(c.duty_inc));
        cfg_write(REG_MIN_VIN, 32'(c.min_vin));
        cfg_write(REG_DEADBAND, 32'(c.deadband));
    endtask

    // Samples mostly follow a slowly drifting current above the voltage floor,
    // so the tracker climbs, reverses and clamps; the rest is noise and faults.
    task automatic pick_item(output t_cmd cmd, output logic [VoltW-1:0] vin,
                             output logic [CurrW-1:0] iin);
        int r;
        int s;
        int v;
        r = $urandom_range(0, 99);
        vin = 16'($urandom_range(0, 65535));
        iin = 16'($urandom_range(0, 65535));
        if (r < 5) begin
            cmd = CMD_ENABLE;
        end else if (r < 9) begin
            cmd = CMD_DISABLE;
        end else if (r < 12) begin
            cmd = CMD_UNUSED;
        end else begin
            cmd = CMD_SAMPLE;
            s = $urandom_range(0, 99);
            if (s < 8) begin
                drift_ma = drift_ma;
            end else if (s < 16 && trk_cfg.min_vin != 0) begin
                vin = 16'($urandom_range(0, int'(trk_cfg.min_vin) - 1));
            end else begin
                v = int'(trk_cfg.min_vin) + int'($urandom_range(0, 3000));
                vin = (v > 65535) ? 16'hFFFF : v[15:0];
                drift_ma = drift_ma + int'($urandom_range(0, 600)) - 300;
                if ($urandom_range(0, 49) == 0) begin
                    drift_ma = $urandom_range(0, 65535);
                end
                if (drift_ma < 0) begin
                    drift_ma = 0;
                end else if (drift_ma > 65535) begin
                    drift_ma = 65535;
                end
                iin = drift_ma[15:0];
            end
        end
    endtask

    task automatic report_field(string fld, int want, int got);
        n_err++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
    endtask

    always @(negedge i_clk) begin : out_stall
        int r;
        if (rdy_hold > 0) begin
            rdy_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                m_axis_tready = 1'b1;
                rdy_hold = $urandom_range(0, 40);
            end else if (r < 90) begin
                m_axis_tready = 1'b0;
                rdy_hold = $urandom_range(0, 2);
            end else begin
                m_axis_tready = 1'b0;
                rdy_hold = $urandom_range(6, 30);
            end
        end
    end

    always @(posedge i_clk) begin : out_check
        t_update want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_updates.size() == 0) begin
                n_err++;
                $display("%0t: unexpected word, expected none, got %h", $time, m_axis_tdata);
            end else begin
                want = expected_updates.pop_front();
                if (m_axis_tdata[7:0] !== want.duty) begin
                    report_field("duty_code", want.duty, m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[10:8] !== want.mode) begin
                    report_field("mode", want.mode, m_axis_tdata[10:8]);
                end
                if (m_axis_tdata[11] !== want.drive) begin
                    report_field("drive_on", want.drive, m_axis_tdata[11]);
                end
                if (m_axis_tdata[12] !== want.up) begin
                    report_field("step_up", want.up, m_axis_tdata[12]);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("** perturb_observe_mppt_core: FAILED **");
        $finish;
    end

    initial begin : stimulus
        t_cmd             cmd;
        logic [VoltW-1:0] vin;
        logic [CurrW-1:0] iin;
        int               n_live;
        bit               mid_done;
        bit               quiet;

        trk_cfg = CFG_RESET;
        trk_mode = STATE_RESET.mode;
        trk_duty = STATE_RESET.duty;
        trk_last_power = STATE_RESET.last_power;
        trk_up = STATE_RESET.dir_up;
        trk_enabled = STATE_RESET.enabled;
        trk_have_last = STATE_RESET.have_last;
        trk_drive = STATE_RESET.drive;

        phase_cfg[0] = '{duty_low: 8'd0, duty_high: 8'd255, duty_init: 8'd0,
                         duty_inc: 7'd1, min_vin: 16'd0, deadband: 32'd0};
        phase_cfg[1] = '{duty_low: 8'd0, duty_high: 8'd255, duty_init: 8'd255,
                         duty_inc: 7'd64, min_vin: 16'hFFFF, deadband: 32'hFFFFFFFF};
        phase_cfg[2] = '{duty_low: 8'd200, duty_high: 8'd50, duty_init: 8'd128,
                         duty_inc: 7'd127, min_vin: 16'd1000, deadband: 32'd5000};
        phase_cfg[3] = '{duty_low: 8'd100, duty_high: 8'd110, duty_init: 8'd105,
                         duty_inc: 7'd0, min_vin: 16'd3000, deadband: 32'd2000000};
        phase_cfg[4] = random_cfg();
        phase_cfg[5] = random_cfg();
        phase_cfg[6] = random_cfg();
        phase_cfg[7] = CFG_RESET;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < NUM_ROWS; k++) begin
            send_word(directed_rows[k].cmd, directed_rows[k].vin, directed_rows[k].iin,
                      directed_rows[k].fixed, directed_rows[k].upd);
            sender_gap(1'b0);
        end
        drain_updates();

        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_cfg(phase_cfg[p]);
            quiet = (p == 2 || p == 5);
            send_word(CMD_ENABLE, 16'd0, 16'd0, 1'b0, NO_UPD);
            n_live = 1;
            mid_done = 1'b0;
            while (n_live < PHASE_WORDS) begin
                pick_item(cmd, vin, iin);
                n_live++;
                send_word(cmd, vin, iin, 1'b0, NO_UPD);
                if (n_live >= PHASE_WORDS / 2 && !mid_done) begin
                    drain_updates();
                    mid_done = 1'b1;
                end else begin
                    sender_gap(quiet);
                end
            end
            drain_updates();
        end

        repeat (8) @(negedge i_clk);
        if (n_err == 0) begin
            $display("** perturb_observe_mppt_core: PASSED **");
        end else begin
            $display("** perturb_observe_mppt_core: FAILED **");
        end
        $finish;
    end

endmodule
